// ===== rtl/source_token_lexer_assert.svh =====
// Assertion macros shared by the lexer modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SOURCE_TOKEN_LEXER_ASSERT_SVH
`define SOURCE_TOKEN_LEXER_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define STL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define STL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define STL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stl_pkg.sv =====
package stl_pkg;

  // Lexing modes.
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_NAME    = 4'd1,
    MODE_INT     = 4'd2,
    MODE_DOT     = 4'd3,
    MODE_FLOAT   = 4'd4,
    MODE_FLOAT_D = 4'd5,
    MODE_BAD     = 4'd6,
    MODE_SPACE   = 4'd7,
    MODE_INVALID = 4'd8
  } mode_t;

  // Token tags.
  localparam logic [3:0] TAG_INVALID  = 4'd0;
  localparam logic [3:0] TAG_NAME     = 4'd1;
  localparam logic [3:0] TAG_TYPE     = 4'd2;
  localparam logic [3:0] TAG_FUNCTION = 4'd3;
  localparam logic [3:0] TAG_LET      = 4'd4;
  localparam logic [3:0] TAG_IF       = 4'd5;
  localparam logic [3:0] TAG_RETURN   = 4'd6;
  localparam logic [3:0] TAG_INT      = 4'd7;
  localparam logic [3:0] TAG_FLOAT    = 4'd8;
  localparam logic [3:0] TAG_BAD      = 4'd9;
  localparam logic [3:0] TAG_DOT      = 4'd10;
  localparam logic [3:0] TAG_SPACE    = 4'd11;
  localparam logic [3:0] TAG_NEWLINE  = 4'd12;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPD   = 8'h44;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOA   = 8'h61;
  localparam logic [7:0] CH_LOD   = 8'h64;
  localparam logic [7:0] CH_LOZ   = 8'h7A;

  // Keywords in tag order: function, let, if, return.
  localparam int KW_NUM = 4;
  localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
    '{8'h66, 8'h75, 8'h6E, 8'h63, 8'h74, 8'h69, 8'h6F, 8'h6E},
    '{8'h6C, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h00, 8'h00}
  };
  localparam logic [15:0] KW_LEN [KW_NUM] = '{16'd8, 16'd3, 16'd2, 16'd6};

  // Channel payloads.
  typedef struct packed {
    logic [7:0] text_byte;
  } byte_item_t;

  typedef struct packed {
    logic [3:0]  token_tag;
    logic [15:0] token_length;
    logic        last_of_run;
  } token_item_t;

  // Results made by one byte: count, then first and second in order.
  typedef struct packed {
    logic [1:0]  n;
    token_item_t r0;
    token_item_t r1;
  } push_t;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

endpackage

// ===== rtl/stl_stream_if.sv =====
interface stl_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/stl_core.sv =====
`include "source_token_lexer_assert.svh"

module stl_core #(
  parameter logic [15:0] LEN_CAP = 16'hFFFF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic [7:0]     text_byte,
  output stl_pkg::push_t push
);

  stl_pkg::mode_t mode_r, mode_nxt, ext_mode;
  logic [15:0] cnt_r, cnt_nxt, cnt_inc;
  logic [3:0]  kw_r, kw_nxt, kw_ext, kw_start;
  logic        fu_r, fu_nxt;

  logic is_upper, is_alpha, is_digit, is_word, is_blank, is_nl, is_nul, is_dot, is_d;
  logic ext;
  logic [3:0] pend_tag;
  logic has_marker;
  stl_pkg::token_item_t pend_item, mark_item;

  always_comb begin
    is_upper = (text_byte >= stl_pkg::CH_UPA) && (text_byte <= stl_pkg::CH_UPZ);
    is_alpha = is_upper || ((text_byte >= stl_pkg::CH_LOA) && (text_byte <= stl_pkg::CH_LOZ));
    is_digit = (text_byte >= stl_pkg::CH_DIG0) && (text_byte <= stl_pkg::CH_DIG9);
    is_word  = is_alpha || is_digit || (text_byte == stl_pkg::CH_UNDER);
    is_blank = (text_byte == stl_pkg::CH_SP) || (text_byte == stl_pkg::CH_TAB) ||
               (text_byte == stl_pkg::CH_CR) || (text_byte == stl_pkg::CH_VT) ||
               (text_byte == stl_pkg::CH_FF);
    is_nl    = (text_byte == stl_pkg::CH_NL);
    is_nul   = (text_byte == stl_pkg::CH_NUL);
    is_dot   = (text_byte == stl_pkg::CH_DOT);
    is_d     = (text_byte == stl_pkg::CH_LOD) || (text_byte == stl_pkg::CH_UPD);
  end

  // Saturating length step and keyword filtering at the current position.
  always_comb begin
    cnt_inc = (cnt_r < LEN_CAP) ? cnt_r + 16'd1 : LEN_CAP;
    for (int k = 0; k < stl_pkg::KW_NUM; k++) begin
      kw_ext[k]   = kw_r[k] && (cnt_r < stl_pkg::KW_LEN[k]) &&
                    (stl_pkg::KW_TEXT[k][cnt_r[2:0]] == text_byte);
      kw_start[k] = (stl_pkg::KW_TEXT[k][0] == text_byte);
    end
  end

  // Does the byte extend the pending token, and into which mode.
  always_comb begin
    ext      = 1'b0;
    ext_mode = mode_r;
    unique case (mode_r) inside
      stl_pkg::MODE_NAME: ext = is_word;
      stl_pkg::MODE_INT: begin
        if (is_digit) begin
          ext = 1'b1;
        end else if (is_dot) begin
          ext      = 1'b1;
          ext_mode = stl_pkg::MODE_FLOAT;
        end
      end
      stl_pkg::MODE_DOT: begin
        ext      = is_digit;
        ext_mode = stl_pkg::MODE_FLOAT;
      end
      stl_pkg::MODE_FLOAT: begin
        if (is_digit) begin
          ext = 1'b1;
        end else if (is_d) begin
          ext      = 1'b1;
          ext_mode = stl_pkg::MODE_FLOAT_D;
        end else if (is_alpha || (text_byte == stl_pkg::CH_UNDER)) begin
          ext      = 1'b1;
          ext_mode = stl_pkg::MODE_BAD;
        end
      end
      stl_pkg::MODE_FLOAT_D, stl_pkg::MODE_BAD: begin
        ext      = is_word;
        ext_mode = stl_pkg::MODE_BAD;
      end
      stl_pkg::MODE_SPACE: ext = is_blank;
      stl_pkg::MODE_INVALID: ext = !is_nul && !is_alpha && !is_digit && !is_dot &&
                                   !is_nl && !is_blank;
      default: ext = 1'b0;
    endcase
  end

  // Tag of the pending token; the first keyword in tag order wins.
  always_comb begin
    pend_tag = stl_pkg::TAG_INVALID;
    unique case (mode_r) inside
      stl_pkg::MODE_NAME: begin
        if (kw_r[0] && (cnt_r == stl_pkg::KW_LEN[0])) begin
          pend_tag = stl_pkg::TAG_FUNCTION;
        end else if (kw_r[1] && (cnt_r == stl_pkg::KW_LEN[1])) begin
          pend_tag = stl_pkg::TAG_LET;
        end else if (kw_r[2] && (cnt_r == stl_pkg::KW_LEN[2])) begin
          pend_tag = stl_pkg::TAG_IF;
        end else if (kw_r[3] && (cnt_r == stl_pkg::KW_LEN[3])) begin
          pend_tag = stl_pkg::TAG_RETURN;
        end else begin
          pend_tag = fu_r ? stl_pkg::TAG_TYPE : stl_pkg::TAG_NAME;
        end
      end
      stl_pkg::MODE_INT:     pend_tag = stl_pkg::TAG_INT;
      stl_pkg::MODE_DOT:     pend_tag = stl_pkg::TAG_DOT;
      stl_pkg::MODE_FLOAT,
      stl_pkg::MODE_FLOAT_D: pend_tag = stl_pkg::TAG_FLOAT;
      stl_pkg::MODE_BAD:     pend_tag = stl_pkg::TAG_BAD;
      stl_pkg::MODE_SPACE:   pend_tag = stl_pkg::TAG_SPACE;
      default:               pend_tag = stl_pkg::TAG_INVALID;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    kw_nxt     = kw_r;
    fu_nxt     = fu_r;
    push       = '0;
    has_marker = is_nul || is_nl;

    pend_item.token_tag    = pend_tag;
    pend_item.token_length = cnt_r;
    pend_item.last_of_run  = !has_marker;
    mark_item.token_tag    = is_nul ? stl_pkg::TAG_INVALID : stl_pkg::TAG_NEWLINE;
    mark_item.token_length = is_nul ? 16'd0 : 16'd1;
    mark_item.last_of_run  = 1'b1;

    if (fire) begin
      if (ext) begin
        mode_nxt = ext_mode;
        cnt_nxt  = cnt_inc;
        if (mode_r == stl_pkg::MODE_NAME) begin
          kw_nxt = kw_ext;
        end
      end else begin
        // The pending token ends here; this byte opens the next one.
        if (mode_r != stl_pkg::MODE_IDLE) begin
          push.n  = has_marker ? 2'd2 : 2'd1;
          push.r0 = pend_item;
          push.r1 = mark_item;
        end else if (has_marker) begin
          push.n  = 2'd1;
          push.r0 = mark_item;
        end
        kw_nxt = '0;
        fu_nxt = 1'b0;
        if (has_marker) begin
          mode_nxt = stl_pkg::MODE_IDLE;
          cnt_nxt  = '0;
        end else begin
          cnt_nxt = 16'd1;
          if (is_alpha || (text_byte == stl_pkg::CH_UNDER)) begin
            mode_nxt = stl_pkg::MODE_NAME;
            kw_nxt   = kw_start;
            fu_nxt   = is_upper;
          end else if (is_digit) begin
            mode_nxt = stl_pkg::MODE_INT;
          end else if (is_dot) begin
            mode_nxt = stl_pkg::MODE_DOT;
          end else if (is_blank) begin
            mode_nxt = stl_pkg::MODE_SPACE;
          end else begin
            mode_nxt = stl_pkg::MODE_INVALID;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stl_pkg::MODE_IDLE;
      cnt_r  <= '0;
      kw_r   <= '0;
      fu_r   <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      kw_r   <= kw_nxt;
      fu_r   <= fu_nxt;
    end
  end

  `STL_ASSERT_IMPL(a_nul_reports, fire && is_nul, push.n != 2'd0,
    "end of text made no result")
  `STL_ASSERT_NEXT(a_marker_idle, fire && has_marker, mode_r == stl_pkg::MODE_IDLE,
    "not idle after end of text or newline")
  `STL_ASSERT_ALWAYS(a_len_cap, cnt_r <= LEN_CAP, "token length above cap")
  `STL_ASSERT_IMPL(a_idle_clear, mode_r == stl_pkg::MODE_IDLE,
    (cnt_r == 16'd0) && (kw_r == 4'd0), "idle state not cleared")

endmodule

// ===== rtl/stl_fifo.sv =====
`include "source_token_lexer_assert.svh"

module stl_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stl_pkg::push_t       push,
  output logic                 space_ok,
  stl_stream_if.source         out_chan
);

  stl_pkg::token_item_t mem_r [stl_pkg::FIFO_DEPTH];
  logic [stl_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [stl_pkg::FIFO_CW-1:0] count_r, count_nxt;
  logic                        pop;

  assign pop            = out_chan.valid && out_chan.ready;
  assign out_chan.valid = (count_r != '0);
  assign out_chan.data  = mem_r[rd_ptr_r];
  // Room for the worst case of two results from one byte.
  assign space_ok       = (count_r <= stl_pkg::FIFO_CW'(stl_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + stl_pkg::FIFO_AW'(push.n);
    rd_ptr_nxt = rd_ptr_r + stl_pkg::FIFO_AW'(pop);
    count_nxt  = count_r + stl_pkg::FIFO_CW'(push.n) - stl_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + stl_pkg::FIFO_AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `STL_ASSERT_ALWAYS(a_fifo_bound, count_r <= stl_pkg::FIFO_CW'(stl_pkg::FIFO_DEPTH),
    "result queue overflow")
  `STL_ASSERT_ALWAYS(a_fifo_ptrs,
    (wr_ptr_r - rd_ptr_r) == count_r[stl_pkg::FIFO_AW-1:0],
    "queue pointers disagree with count")
  `STL_ASSERT_NEXT(a_fifo_hold, out_chan.valid && !out_chan.ready,
    out_chan.valid && $stable(out_chan.data), "stalled token changed")

endmodule

// ===== rtl/source_token_lexer.sv =====
// Streaming lexer for source text.
// Input channel in_chan carries one text byte per transfer; byte 0 marks end of text.
// Output channel out_chan carries one token per transfer: tag, byte length and a flag
// that marks the last token caused by a given input byte. A byte produces zero, one or
// two tokens: a token is reported only once the byte after it shows where it ends, a
// newline is reported on its own byte, and end of text flushes the pending token and
// then reports an invalid token of length 0.
// A byte accepted into the input register is decoded once the result queue has room
// for its tokens, which are then registered in the queue and offered on out_chan.
// Throughput: one byte per cycle. Each byte passes through an input register, the
// lexer state update and a four-entry result queue; a byte is decoded only while the
// queue has room for two tokens, so sustained rate is also bounded by the sink taking
// one token per cycle.
// Reset (rst_n low at a clock edge) returns the lexer to idle with no token pending
// and empties the input register and the result queue.
// When the sink stalls, queued tokens hold in order; once the queue is nearly full
// the input register stops draining and in_chan.ready drops while it holds a byte.
// Token lengths saturate at the smaller of MAX_TOKEN_LEN and 65535.
module source_token_lexer #(
  parameter longint unsigned MAX_TOKEN_LEN = 65535
) (
  input  logic         clk,
  input  logic         rst_n,
  stl_stream_if.sink   in_chan,
  stl_stream_if.source out_chan
);

  // Length cap, limited by the 16-bit length field.
  localparam logic [15:0] LEN_CAP = (MAX_TOKEN_LEN < 64'd65535) ?
                                    16'(MAX_TOKEN_LEN) : 16'hFFFF;

  logic           in_v_r;
  logic [7:0]     in_byte_r;
  logic           space_ok;
  logic           fire;
  stl_pkg::push_t push;

  // The held byte is decoded once the queue can take its results.
  assign fire          = in_v_r && space_ok;
  // The input register refills in the same cycle that it drains.
  assign in_chan.ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  // The byte register needs no reset; in_v_r qualifies it.
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.data.text_byte;
    end
  end

  stl_core #(
    .LEN_CAP (LEN_CAP)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .text_byte (in_byte_r),
    .push      (push)
  );

  stl_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_chan (out_chan)
  );

endmodule

// ===== tb/sv/lexer_token_check.sv =====
module lexer_token_check
  import stl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  byte_item_t  in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  token_item_t out_data,
  output int          fail_count,
  output int          tokens_open
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] LEN_CAP = 16'hFFFF;
  localparam logic [3:0] KW_TAG [KW_NUM] = '{TAG_FUNCTION, TAG_LET, TAG_IF, TAG_RETURN};

  // Lexer state as this side sees it.
  mode_t       lex_state;
  logic [15:0] run_len;
  logic [3:0]  kw_live;
  logic        upper_start;

  token_item_t tokens_due [$];
  token_item_t seen;
  token_item_t want;

  function automatic bit is_upper(input logic [7:0] c);
    return c >= CH_UPA && c <= CH_UPZ;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return is_upper(c) || (c >= CH_LOA && c <= CH_LOZ);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_DIG0 && c <= CH_DIG9;
  endfunction

  function automatic bit is_word(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
  endfunction

  function automatic void clear_state();
    lex_state   = MODE_IDLE;
    run_len     = '0;
    kw_live     = '0;
    upper_start = 1'b0;
  endfunction

  function automatic void bump_len();
    if (run_len != LEN_CAP) run_len++;
  endfunction

  // Drops every keyword that no longer matches at the current position.
  function automatic void add_name_char(input logic [7:0] c);
    for (int k = 0; k < KW_NUM; k++) begin
      if (kw_live[k]) begin
        if (run_len >= KW_LEN[k]) kw_live[k] = 1'b0;
        else if (KW_TEXT[k][run_len[2:0]] != c) kw_live[k] = 1'b0;
      end
    end
    bump_len();
  endfunction

  function automatic logic [3:0] finished_tag();
    case (lex_state)
      MODE_NAME: begin
        for (int k = 0; k < KW_NUM; k++)
          if (kw_live[k] && run_len == KW_LEN[k]) return KW_TAG[k];
        return upper_start ? TAG_TYPE : TAG_NAME;
      end
      MODE_INT:                 return TAG_INT;
      MODE_DOT:                 return TAG_DOT;
      MODE_FLOAT, MODE_FLOAT_D: return TAG_FLOAT;
      MODE_BAD:                 return TAG_BAD;
      MODE_SPACE:               return TAG_SPACE;
      default:                  return TAG_INVALID;
    endcase
  endfunction

  // True when the byte continues the token in progress.
  function automatic bit continues_token(input logic [7:0] c);
    case (lex_state)
      MODE_NAME: begin
        if (!is_word(c)) return 1'b0;
        add_name_char(c);
        return 1'b1;
      end
      MODE_INT: begin
        if (c == CH_DOT) lex_state = MODE_FLOAT;
        else if (!is_digit(c)) return 1'b0;
      end
      MODE_DOT: begin
        if (!is_digit(c)) return 1'b0;
        lex_state = MODE_FLOAT;
      end
      MODE_FLOAT: begin
        if (c == CH_LOD || c == CH_UPD) lex_state = MODE_FLOAT_D;
        else if (is_letter(c) || c == CH_UNDER) lex_state = MODE_BAD;
        else if (!is_digit(c)) return 1'b0;
      end
      MODE_FLOAT_D, MODE_BAD: begin
        if (!is_word(c)) return 1'b0;
        lex_state = MODE_BAD;
      end
      MODE_SPACE: begin
        if (!is_blank(c)) return 1'b0;
      end
      MODE_INVALID: begin
        if (c == CH_NUL || is_letter(c) || is_digit(c) || c == CH_DOT || c == CH_NL ||
            is_blank(c)) return 1'b0;
      end
      default: return 1'b0;
    endcase
    bump_len();
    return 1'b1;
  endfunction

  // Queues the tokens that one text byte finishes, at most two of them.
  function automatic void lex_text_byte(input logic [7:0] c);
    bit          have_flush;
    bit          have_own;
    token_item_t flush_tok;
    token_item_t own_tok;
    if (lex_state != MODE_IDLE && continues_token(c)) return;
    have_flush = (lex_state != MODE_IDLE);
    flush_tok  = '{token_tag: finished_tag(), token_length: run_len, last_of_run: 1'b0};
    clear_state();
    have_own = 1'b1;
    own_tok  = '{token_tag: TAG_INVALID, token_length: 16'd0, last_of_run: 1'b1};
    if (c == CH_NL) begin
      own_tok.token_tag    = TAG_NEWLINE;
      own_tok.token_length = 16'd1;
    end else if (c != CH_NUL) begin
      have_own = 1'b0;
      if (is_letter(c) || c == CH_UNDER) begin
        lex_state   = MODE_NAME;
        kw_live     = '1;
        upper_start = is_upper(c);
        add_name_char(c);
      end else begin
        if (is_digit(c)) lex_state = MODE_INT;
        else if (c == CH_DOT) lex_state = MODE_DOT;
        else if (is_blank(c)) lex_state = MODE_SPACE;
        else lex_state = MODE_INVALID;
        bump_len();
      end
    end
    if (have_flush) begin
      flush_tok.last_of_run = !have_own;
      tokens_due.push_back(flush_tok);
    end
    if (have_own) tokens_due.push_back(own_tok);
  endfunction

  initial begin
    fail_count  = 0;
    tokens_open = 0;
    clear_state();
  end

  // Inputs are taken before outputs: a byte never yields a token in the cycle it enters.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      tokens_due.delete();
    end else begin
      if (in_valid && in_ready) lex_text_byte(in_data.text_byte);
      if (out_valid && out_ready) begin
        seen = out_data;
        if (tokens_due.size() == 0) begin
          $error("unexpected token: token_tag %0d token_length %0d last_of_run %0b",
                 seen.token_tag, seen.token_length, seen.last_of_run);
          fail_count++;
        end else begin
          want = tokens_due.pop_front();
          if (seen.token_tag !== want.token_tag) begin
            $error("token_tag: expected %0d, actual %0d", want.token_tag, seen.token_tag);
            fail_count++;
          end
          if (seen.token_length !== want.token_length) begin
            $error("token_length: expected %0d, actual %0d",
                   want.token_length, seen.token_length);
            fail_count++;
          end
          if (seen.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run, seen.last_of_run);
            fail_count++;
          end
        end
      end
    end
    tokens_open <= tokens_due.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import stl_pkg::*;

  // Length of the random part in text bytes, and how it is cut into phases.
  localparam int RANDOM_BYTES = 780;
  localparam int PHASE_BYTES  = 100;
  // A type name far longer than any keyword.
  localparam int LONG_NAME_BYTES = 40;
  // Cycles the token sink refuses transfers during the back-pressure phase.
  localparam int SINK_HOLD_CYCLES = 200;
  // Upper bound on the run. About 900 bytes are sent; each costs at most one input
  // gap plus two tokens that each wait out one sink stall, so the limit is ample.
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   tokens_open;
  int   cycle_count;
  int   bytes_sent;
  bit   no_idle;
  bit   sink_hold_req;

  // Word list that sits on and around the keywords, so partial and overlong matches
  // are exercised as well as the exact spellings.
  string keyword_like [12] = '{"function", "let", "if", "return", "functio", "functions",
                               "lets", "i", "ifx", "return_", "Return", "Function"};
  // Punctuation that starts an invalid run; '.' and '_' are left out on purpose.
  string punct_set = "!#$%&()*+,-/:;<=>?@[]^{|}~";

  stl_stream_if #(.payload_t(byte_item_t))  in_chan ();
  stl_stream_if #(.payload_t(token_item_t)) out_chan ();

  source_token_lexer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  lexer_token_check token_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_data     (in_chan.data),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_data    (out_chan.data),
    .fail_count  (fail_count),
    .tokens_open (tokens_open)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Hard stop in case the block hangs or a token never shows up.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** source_token_lexer: FAILED **");
      $finish;
    end
  end

  // Offers one text byte after a random gap and returns once the transfer has happened.
  // With no gap, valid simply stays high and only the data changes.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= b;
    do @(posedge clk); while (!in_chan.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stops offering bytes until every token owed so far has been transferred.
  task automatic wait_tokens_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (tokens_open != 0);
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(CH_LOA, CH_LOZ));
      1:       return 8'($urandom_range(CH_UPA, CH_UPZ));
      2:       return 8'($urandom_range(CH_DIG0, CH_DIG9));
      default: return CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'($urandom_range(CH_DIG0, CH_DIG9));
  endfunction

  function automatic logic [7:0] punct_char();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(128, 255));
    return punct_set[$urandom_range(0, punct_set.len() - 1)];
  endfunction

  task automatic send_digits(input int count);
    repeat (count) send_byte(digit_char());
  endtask

  // One token's worth of text, mostly well formed. Tokens are glued together with no
  // separator, so neighbors also merge and split in less obvious ways. Noise bytes
  // cover control codes and the full byte range.
  task automatic emit_random_token();
    int pick;
    int shape;
    int suffix;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_text(keyword_like[$urandom_range(0, 11)]);
    end else if (pick < 30) begin
      case ($urandom_range(0, 2))
        0:       send_byte(8'($urandom_range(CH_LOA, CH_LOZ)));
        1:       send_byte(8'($urandom_range(CH_UPA, CH_UPZ)));
        default: send_byte(CH_UNDER);
      endcase
      repeat ($urandom_range(0, 8)) send_byte(word_char());
    end else if (pick < 40) begin
      send_digits($urandom_range(1, 5));
    end else if (pick < 55) begin
      // Floats: digits.digits, .digits or digits. with an optional d/D suffix, or a
      // letter or underscore tail that turns the token into a bad float.
      shape = $urandom_range(0, 2);
      if (shape != 1) send_digits($urandom_range(1, 3));
      send_byte(CH_DOT);
      if (shape != 2) send_digits($urandom_range(1, 3));
      suffix = $urandom_range(0, 4);
      if (suffix == 1) send_byte(CH_LOD);
      else if (suffix == 2) send_byte(CH_UPD);
      else if (suffix == 3) send_byte($urandom_range(0, 1) ? CH_UNDER : 8'h65);
      if (suffix >= 3 || (suffix != 0 && $urandom_range(0, 1) == 1))
        repeat ($urandom_range(1, 3)) send_byte(word_char());
    end else if (pick < 60) begin
      send_byte(CH_DOT);
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 4))
          0:       send_byte(CH_SP);
          1:       send_byte(CH_TAB);
          2:       send_byte(CH_CR);
          3:       send_byte(CH_VT);
          default: send_byte(CH_FF);
        endcase
      end
    end else if (pick < 76) begin
      send_byte(CH_NL);
    end else if (pick < 84) begin
      // Invalid run: punctuation or a high byte first, then more of either or '_'.
      send_byte(punct_char());
      repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 2) == 0 ? CH_UNDER : punct_char());
    end else if (pick < 87) begin
      send_byte(CH_NUL);
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Token sink. It stalls a random number of cycles before each transfer, except in
  // the phases that run without idling. On request it refuses transfers for a long
  // stretch so the result queue fills and the block pushes back on its input.
  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (sink_hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
          out_chan.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_chan.ready <= 1'b1;
        do @(posedge clk); while (!out_chan.valid);
      end
    end
  end

  // Text source and verdict.
  initial begin
    int rand_start;
    int phase;
    int phase_stop;
    bytes_sent    = 0;
    no_idle       = 1'b0;
    sink_hold_req = 1'b0;
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed text: keywords if and let, a newline, blanks, a type name, an int, a
    // float with a d suffix cut by a lone dot, a plain name, an invalid run that starts
    // with byte 255 and is extended by '_', a float that starts with '.', a bad float
    // from a letter after the digits, and end of text flushing it with byte 0.
    send_text("if\nlet Ab 7 1.2d.x");
    send_byte(8'hFF);
    send_text("_.5e");
    send_byte(CH_NUL);

    // A long type name sent back to back with no idling.
    no_idle = 1'b1;
    send_byte(CH_UPA);
    repeat (LONG_NAME_BYTES - 1) send_byte(8'h78);
    send_byte(CH_SP);
    no_idle = 1'b0;

    // Random text in phases. Every third phase runs with no idling on either side.
    // Phase one asks the sink for a long hold while bytes keep coming; phase four
    // starts only after every token owed so far has been transferred.
    rand_start = bytes_sent;
    phase = 0;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      no_idle = (phase % 3 == 2);
      if (phase == 1) sink_hold_req = 1'b1;
      if (phase == 4) wait_tokens_drained();
      phase_stop = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_stop) emit_random_token();
      phase++;
    end
    // End of text flushes whatever token is still open.
    send_byte(CH_NUL);

    wait_tokens_drained();
    // Keep watching for any stray token before the verdict.
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** source_token_lexer: PASSED **");
    end else begin
      $display("** source_token_lexer: FAILED **");
    end
    $finish;
  end

endmodule
